// ===== rtl/core/pss_pkg.sv =====
// Shared types, constants and helpers for the polyline segment stroker.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package pss_pkg;

  // Coordinate width (signed, 8 fraction bits)
  localparam int COORD_W = 24;
  // Magnitude register: holds a coordinate difference and room to detect 2^25
  localparam int MAG_W = ((COORD_W > 25) ? COORD_W : 25) + 1;
  // Vertex sum width: coordinate plus an 18-bit offset, one guard bit
  localparam int SUM_W = ((COORD_W > 18) ? COORD_W : 18) + 1;
  localparam int NRM_W = 18;   // normal, signed Q2.16
  localparam int DIV_W = 48;   // dividend / quotient width

  localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;
  localparam logic [15:0] HALF_WIDTH_RST = 16'd256;
  localparam logic [31:0] JOIN_COLOR_RST = 32'hFFFF_FFFF;

  // Register indexes
  localparam logic CFG_HALF_WIDTH = 1'b0;
  localparam logic CFG_JOIN_COLOR = 1'b1;

  // Point request from the front queue
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               start;
  } point_req_t;

  // Finished segment handed from geometry to vertex emission
  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [NRM_W-1:0]   wx;
    logic [NRM_W-1:0]   wy;
    logic [NRM_W-1:0]   px;
    logic [NRM_W-1:0]   py;
    logic [31:0]        u0;
    logic [31:0]        u1;
    logic               join_en;
  } seg_job_t;

  typedef enum logic [3:0] {
    G_IDLE, G_NORM, G_SQA, G_SQB, G_SQRT, G_DIVX, G_DIVY, G_DIVL, G_SCALE, G_HAND
  } geom_state_t;

  typedef enum logic [2:0] {
    OFF_NONE, OFF_PLUS_W, OFF_MINUS_W, OFF_PLUS_P, OFF_MINUS_P
  } off_sel_t;

  typedef struct packed {
    logic     base_b;    // 1: new point b, 0: stored point a
    off_sel_t off;
    logic     use_u1;
    logic [1:0] vh;
    logic     join_col;
  } vtx_info_t;

  // Vertex order: quad triangles first, then the two join triangles
  function automatic vtx_info_t vtx_info(input logic [3:0] idx);
    vtx_info_t v;
    v = '{base_b: 1'b0, off: OFF_NONE, use_u1: 1'b0, vh: 2'd0, join_col: 1'b0};
    case (idx)
      4'd0:  v = '{1'b1, OFF_PLUS_W,  1'b1, 2'd2, 1'b0};
      4'd1:  v = '{1'b0, OFF_MINUS_W, 1'b0, 2'd0, 1'b0};
      4'd2:  v = '{1'b1, OFF_MINUS_W, 1'b1, 2'd0, 1'b0};
      4'd3:  v = '{1'b1, OFF_PLUS_W,  1'b1, 2'd2, 1'b0};
      4'd4:  v = '{1'b0, OFF_MINUS_W, 1'b0, 2'd0, 1'b0};
      4'd5:  v = '{1'b0, OFF_PLUS_W,  1'b0, 2'd2, 1'b0};
      4'd6:  v = '{1'b0, OFF_NONE,    1'b0, 2'd1, 1'b1};
      4'd7:  v = '{1'b0, OFF_PLUS_W,  1'b0, 2'd2, 1'b1};
      4'd8:  v = '{1'b0, OFF_PLUS_P,  1'b0, 2'd2, 1'b1};
      4'd9:  v = '{1'b0, OFF_NONE,    1'b0, 2'd1, 1'b0};
      4'd10: v = '{1'b0, OFF_MINUS_P, 1'b0, 2'd0, 1'b0};
      4'd11: v = '{1'b0, OFF_MINUS_W, 1'b0, 2'd0, 1'b0};
      default: v = '{1'b0, OFF_NONE, 1'b0, 2'd0, 1'b0};
    endcase
    return v;
  endfunction

  // Clamp a widened sum to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/polyline_segment_stroker.sv =====
// Polyline segment stroker top level: config registers, front queue, geometry, emission.
// Depends on pss_pkg, pss_front, pss_geom, pss_emit.
//
// Usage: points enter on in_valid/in_ready (point_x, point_y, line_start). A request
// with line_start set, or the first point after reset, only stores the point and
// clears the running length and stored normal; it emits nothing. Every other point
// closes a segment and yields 6 vertices, or 12 when a join to the previous segment
// exists, on out_valid/out_ready; last_vertex marks the final one.
// Path of a segment point: the input queue, the accept (idle) state, normalization,
// the two squares, the square root, the three divisions, offset scaling, the handoff
// and the load of the output register, which then offers the first vertex. Vertices
// then leave at one per cycle while the receiver takes them, overlapped with the next
// point's geometry. A 2-entry input queue keeps accepting points meanwhile.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
// the block itself does not enforce this.
// Reset (rst, synchronous) clears all control state, the stored point and normal,
// the running length, and loads half_width = 1.0 and join_color = white.
// When the receiver stalls, the output register holds its vertex and geometry
// for the next point waits at its handoff; input is refused when the queue fills.
`default_nettype none
module polyline_segment_stroker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pss_pkg::COORD_W-1:0] point_x,
  input  wire logic [pss_pkg::COORD_W-1:0] point_y,
  input  wire logic                        line_start,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pss_pkg::COORD_W-1:0]      vertex_x,
  output logic [pss_pkg::COORD_W-1:0]      vertex_y,
  output logic [31:0]                      vertex_color,
  output logic [31:0]                      tex_u,
  output logic [1:0]                       tex_v_half,
  output logic                             last_vertex
);

  logic [15:0] half_width;
  logic [31:0] join_color;

  logic                q_valid, q_ready;
  pss_pkg::point_req_t q_req;
  logic                job_valid, job_ready;
  pss_pkg::seg_job_t   job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= pss_pkg::HALF_WIDTH_RST;
      join_color <= pss_pkg::JOIN_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::CFG_HALF_WIDTH: half_width <= cfg_data[15:0];
        pss_pkg::CFG_JOIN_COLOR: join_color <= cfg_data;
        default: ;
      endcase
    end
  end

  pss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .line_start (line_start),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req)
  );

  pss_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .half_width (half_width),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  pss_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .join_color   (join_color),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_color (vertex_color),
    .tex_u        (tex_u),
    .tex_v_half   (tex_v_half),
    .last_vertex  (last_vertex)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pss_front.sv =====
// Front end: accepts points, marks line starts, buffers them in a 2-entry queue.
// Depends on pss_pkg.
`default_nettype none
module pss_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pss_pkg::COORD_W-1:0] point_x,
  input  wire logic [pss_pkg::COORD_W-1:0] point_y,
  input  wire logic                        line_start,
  output logic                             q_valid,
  input  wire logic                        q_ready,
  output pss_pkg::point_req_t              q_req
);

  pss_pkg::point_req_t fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       seen;     // a point has been stored since reset

  logic push;
  logic pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = fifo[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage; first point after reset counts as a line start
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{x: point_x, y: point_y, start: line_start || !seen};
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      seen   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
        seen   <= 1'b1;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pss_geom.sv =====
// Segment geometry: normalization, square root, three divisions, offset scaling.
// Holds the line state (stored point, normal, running length). Depends on pss_pkg.
`default_nettype none
module pss_geom (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         half_width,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire pss_pkg::point_req_t q_req,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output pss_pkg::seg_job_t        job
);

  localparam int CW = pss_pkg::COORD_W;
  localparam int MW = pss_pkg::MAG_W;
  localparam int NW = pss_pkg::NRM_W;
  localparam int DW = pss_pkg::DIV_W;

  pss_pkg::geom_state_t state, state_next;

  // line state
  logic signed [CW-1:0] prev_x, prev_y;
  logic [NW-1:0]        prev_nx, prev_ny;
  logic [31:0]          run_length;

  // segment working registers
  logic signed [CW-1:0] bx, by;
  logic [MW-1:0]        ma, mb;
  logic                 dx_neg, dy_neg;
  logic [4:0]           s_sh, t_sh;
  logic [50:0]          acc;
  logic [63:0]          sq_rem, sq_res, sq_bit;
  logic [4:0]           sq_cnt;
  logic [DW-1:0]        div_num;
  logic [31:0]          div_rem, div_den;
  logic [5:0]           div_cnt;
  logic [NW-1:0]        nx, ny;
  logic [31:0]          seg;
  logic [NW-1:0]        wx, wy, px, py;
  logic [1:0]           sc_cnt;

  // combinational helpers
  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      adx, ady;
  logic [MW-1:0]      mmax;
  logic [24:0]        sq_op;
  logic [49:0]        sq;
  logic [63:0]        sq_trial;
  logic [32:0]        div_trial;
  logic               div_bit;
  logic [DW-1:0]      div_q;
  logic [16:0]        q_cap;
  logic [31:0]        r_val;
  logic [31:0]        len_den;
  logic [DW-1:0]      len_num;
  logic [NW-1:0]      sc_src;
  logic [16:0]        sc_mag;
  logic [32:0]        sc_prod;
  logic [32:0]        sc_rnd;
  logic [NW-1:0]      sc_off;
  logic [32:0]        u_sum;

  assign dx   = {q_req.x[CW-1], q_req.x} - {prev_x[CW-1], prev_x};
  assign dy   = {q_req.y[CW-1], q_req.y} - {prev_y[CW-1], prev_y};
  assign adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign mmax = (ma > mb) ? ma : mb;

  // one shared squarer
  assign sq_op = (state == pss_pkg::G_SQA) ? ma[24:0] : mb[24:0];
  assign sq    = sq_op * sq_op;

  // square root step
  assign sq_trial = sq_res + sq_bit;

  // restoring division step; quotient bits shift into div_num
  assign div_trial = {div_rem, div_num[DW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_den});
  assign div_q     = {div_num[DW-2:0], div_bit};
  assign q_cap     = (div_q > DW'(65536)) ? 17'h10000 : div_q[16:0];
  assign r_val     = sq_res[31:0];
  assign len_den   = 32'd100 << s_sh;
  assign len_num   = ((DW'(r_val) << 2) << t_sh) + DW'(len_den >> 1);

  // offset scaling: |n| * half_width rounded to 8 fraction bits
  always_comb begin
    case (sc_cnt)
      2'd0:    sc_src = nx;
      2'd1:    sc_src = ny;
      2'd2:    sc_src = prev_nx;
      default: sc_src = prev_ny;
    endcase
  end
  assign sc_mag  = sc_src[NW-1] ? 17'(-sc_src) : sc_src[16:0];
  assign sc_prod = sc_mag * half_width;
  assign sc_rnd  = sc_prod + 33'h0_8000;
  assign sc_off  = sc_src[NW-1] ? -{1'b0, sc_rnd[32:16]} : {1'b0, sc_rnd[32:16]};

  assign u_sum = {1'b0, run_length} + {1'b0, seg};

  // job output
  assign job = '{ax: prev_x, ay: prev_y, bx: bx, by: by, wx: wx, wy: wy, px: px, py: py,
                  u0: run_length, u1: (u_sum[32] ? 32'hFFFF_FFFF : u_sum[31:0]),
                  join_en: (prev_nx != '0) || (prev_ny != '0)};

  // next state and handshakes
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    job_valid  = 1'b0;
    case (state)
      pss_pkg::G_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && !q_req.start) begin
          state_next = ((adx == '0) && (ady == '0)) ? pss_pkg::G_SCALE : pss_pkg::G_NORM;
        end
      end
      pss_pkg::G_NORM: begin
        if (((mmax >> 24) != '0) && ((mmax >> 25) == '0)) state_next = pss_pkg::G_SQA;
      end
      pss_pkg::G_SQA:  state_next = pss_pkg::G_SQB;
      pss_pkg::G_SQB:  state_next = pss_pkg::G_SQRT;
      pss_pkg::G_SQRT: if (sq_cnt == '0) state_next = pss_pkg::G_DIVX;
      pss_pkg::G_DIVX: if (div_cnt == '0) state_next = pss_pkg::G_DIVY;
      pss_pkg::G_DIVY: if (div_cnt == '0) state_next = pss_pkg::G_DIVL;
      pss_pkg::G_DIVL: if (div_cnt == '0) state_next = pss_pkg::G_SCALE;
      pss_pkg::G_SCALE: if (sc_cnt == 2'd3) state_next = pss_pkg::G_HAND;
      pss_pkg::G_HAND: begin
        job_valid = 1'b1;
        if (job_ready) state_next = pss_pkg::G_IDLE;
      end
      default: state_next = pss_pkg::G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pss_pkg::G_IDLE;
    else     state <= state_next;
  end

  // line state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_y     <= '0;
      prev_nx    <= '0;
      prev_ny    <= '0;
      run_length <= '0;
    end else if (state == pss_pkg::G_IDLE && q_valid && q_req.start) begin
      prev_x     <= q_req.x;
      prev_y     <= q_req.y;
      prev_nx    <= '0;
      prev_ny    <= '0;
      run_length <= '0;
    end else if (state == pss_pkg::G_HAND && job_ready) begin
      prev_x     <= bx;
      prev_y     <= by;
      prev_nx    <= nx;
      prev_ny    <= ny;
      run_length <= job.u1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      pss_pkg::G_IDLE: begin
        bx     <= q_req.x;
        by     <= q_req.y;
        ma     <= MW'(adx);
        mb     <= MW'(ady);
        dx_neg <= dx[CW];
        dy_neg <= dy[CW];
        s_sh   <= '0;
        t_sh   <= '0;
        nx     <= '0;
        ny     <= '0;
        seg    <= '0;
        sc_cnt <= '0;
      end
      pss_pkg::G_NORM: begin
        // one bit per cycle until the larger magnitude is in [2^24, 2^25)
        if ((mmax >> 24) == '0) begin
          ma   <= ma << 1;
          mb   <= mb << 1;
          s_sh <= s_sh + 5'd1;
        end else if ((mmax >> 25) != '0) begin
          ma   <= ma >> 1;
          mb   <= mb >> 1;
          t_sh <= t_sh + 5'd1;
        end
      end
      pss_pkg::G_SQA: acc <= 51'(sq);
      pss_pkg::G_SQB: begin
        sq_rem <= {1'b0, acc + 51'(sq), 12'd0};
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
        sq_cnt <= 5'd31;
      end
      pss_pkg::G_SQRT: begin
        if (sq_rem >= sq_trial) begin
          sq_rem <= sq_rem - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 5'd1;
        if (sq_cnt == '0) begin
          div_num <= DW'({mb[24:0], 22'd0}) + DW'((sq_res >> 1) + (sq_bit >> 1));
          div_den <= '0;
          div_rem <= '0;
          div_cnt <= 6'(DW - 1);
        end
      end
      pss_pkg::G_DIVX, pss_pkg::G_DIVY, pss_pkg::G_DIVL: begin
        div_num <= div_q;
        div_rem <= div_bit ? 32'(div_trial - {1'b0, div_den}) : div_trial[31:0];
        div_cnt <= div_cnt - 6'd1;
        if (div_cnt == '0) begin
          div_rem <= '0;
          div_cnt <= 6'(DW - 1);
          if (state == pss_pkg::G_DIVX) begin
            nx      <= dy_neg ? {1'b0, q_cap} : -{1'b0, q_cap};
            div_num <= DW'({ma[24:0], 22'd0}) + DW'(r_val >> 1);
          end else if (state == pss_pkg::G_DIVY) begin
            ny      <= dx_neg ? -{1'b0, q_cap} : {1'b0, q_cap};
            div_num <= len_num;
            div_den <= len_den;
          end else begin
            seg <= (div_q[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
          end
        end
      end
      pss_pkg::G_SCALE: begin
        case (sc_cnt)
          2'd0:    wx <= sc_off;
          2'd1:    wy <= sc_off;
          2'd2:    px <= sc_off;
          default: py <= sc_off;
        endcase
        sc_cnt <= sc_cnt + 2'd1;
      end
      default: ;
    endcase
    // divisor for the normal divisions is the root just found
    if (state == pss_pkg::G_SQRT && sq_cnt == '0) begin
      div_den <= (sq_rem >= sq_trial) ? 32'((sq_res >> 1) + sq_bit) : 32'(sq_res >> 1);
      div_num <= DW'({mb[24:0], 22'd0})
               + DW'(((sq_rem >= sq_trial) ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1)) >> 1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pss_emit.sv =====
// Vertex emission: walks the vertex table for one segment into an output register.
// Depends on pss_pkg.
`default_nettype none
module pss_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [31:0]                 join_color,
  input  wire logic                        job_valid,
  output logic                             job_ready,
  input  wire pss_pkg::seg_job_t           job,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pss_pkg::COORD_W-1:0]      vertex_x,
  output logic [pss_pkg::COORD_W-1:0]      vertex_y,
  output logic [31:0]                      vertex_color,
  output logic [31:0]                      tex_u,
  output logic [1:0]                       tex_v_half,
  output logic                             last_vertex
);

  localparam int CW = pss_pkg::COORD_W;
  localparam int SW = pss_pkg::SUM_W;
  localparam int NW = pss_pkg::NRM_W;

  pss_pkg::seg_job_t cur;
  logic              busy;
  logic [3:0]        idx;

  pss_pkg::vtx_info_t  vi;
  logic signed [CW-1:0] base_x, base_y;
  logic signed [NW-1:0] off_x, off_y;
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 load;
  logic                 is_last;

  assign job_ready = !busy;
  assign load      = busy && (!out_valid || out_ready);
  assign vi        = pss_pkg::vtx_info(idx);
  assign is_last   = (idx == (cur.join_en ? 4'd11 : 4'd5));

  // vertex position: base point plus selected offset
  always_comb begin
    base_x = vi.base_b ? $signed(cur.bx) : $signed(cur.ax);
    base_y = vi.base_b ? $signed(cur.by) : $signed(cur.ay);
    case (vi.off)
      pss_pkg::OFF_PLUS_W: begin
        off_x = $signed(cur.wx);
        off_y = $signed(cur.wy);
      end
      pss_pkg::OFF_MINUS_W: begin
        off_x = -$signed(cur.wx);
        off_y = -$signed(cur.wy);
      end
      pss_pkg::OFF_PLUS_P: begin
        off_x = $signed(cur.px);
        off_y = $signed(cur.py);
      end
      pss_pkg::OFF_MINUS_P: begin
        off_x = -$signed(cur.px);
        off_y = -$signed(cur.py);
      end
      default: begin
        off_x = '0;
        off_y = '0;
      end
    endcase
    sum_x = SW'(base_x) + SW'(off_x);
    sum_y = SW'(base_y) + SW'(off_y);
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && !busy) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        idx <= idx + 4'd1;
        if (is_last) busy <= 1'b0;
      end
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // job capture and output payload
  always_ff @(posedge clk) begin
    if (job_valid && !busy) cur <= job;
    if (load) begin
      vertex_x     <= pss_pkg::sat_coord(sum_x);
      vertex_y     <= pss_pkg::sat_coord(sum_y);
      vertex_color <= vi.join_col ? join_color : pss_pkg::WHITE_RGBA;
      tex_u        <= vi.use_u1 ? cur.u1 : cur.u0;
      tex_v_half   <= vi.vh;
      last_vertex  <= is_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pss_checker.sv =====
// Port-level checks for the polyline segment stroker, bound to the top level.
// Depends on pss_pkg and polyline_segment_stroker.
`default_nettype none
module pss_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pss_pkg::COORD_W-1:0] vertex_x,
  input wire logic [pss_pkg::COORD_W-1:0] vertex_y,
  input wire logic [31:0]                 vertex_color,
  input wire logic [31:0]                 tex_u,
  input wire logic [1:0]                  tex_v_half,
  input wire logic                        last_vertex
);

  // a stalled vertex stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("vertex dropped while stalled");

  // a stalled vertex keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vertex_x) && $stable(vertex_y) &&
      $stable(vertex_color) && $stable(tex_u) && $stable(tex_v_half) &&
      $stable(last_vertex))
    else $error("vertex payload changed while stalled");

  // nothing offered right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("vertex offered after reset");

  // v is 0, 0.5 or 1 only
  a_v_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_v_half != 2'd3)
    else $error("tex_v_half out of range");

  // the join colour only appears on the upward join triangle (v of 0.5 or 1)
  a_color_v: assert property (@(posedge clk) disable iff (rst)
    out_valid && vertex_color != pss_pkg::WHITE_RGBA |-> tex_v_half != 2'd0)
    else $error("join colour on a lower vertex");

endmodule

bind polyline_segment_stroker pss_checker u_pss_checker (.*);
`default_nettype wire
